>>> hdl/text_terminal_char_writer_defines.svh
// Assertion macros for the files that check their own logic.
// Each macro expects signals named clk and rst_n in the scope of its use.
`ifndef TEXT_TERMINAL_CHAR_WRITER_DEFINES_SVH
`define TEXT_TERMINAL_CHAR_WRITER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTCW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TTCW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ttcw_pkg.sv
`default_nettype none

package ttcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int INDEX_W = 11;
  localparam int WORD_W  = 16;

  localparam logic [CHAR_W-1:0]  CH_NEWLINE  = 8'd10;
  localparam logic [CHAR_W-1:0]  CH_TAB      = 8'd9;
  localparam int                 TAB_STEP    = 4;
  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd138;

  typedef struct packed {
    logic               cell_write;
    logic [INDEX_W-1:0] cell_index;
    logic [WORD_W-1:0]  cell_word;
    logic [INDEX_W-1:0] cursor_index;
  } ttcw_result_t;

endpackage

`default_nettype wire

>>> hdl/ttcw_if.sv
`default_nettype none

interface ttcw_in_if;
  logic                        valid;
  logic                        ready;
  logic [ttcw_pkg::CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface ttcw_out_if;
  logic                         valid;
  logic                         ready;
  logic                         cell_write;
  logic [ttcw_pkg::INDEX_W-1:0] cell_index;
  logic [ttcw_pkg::WORD_W-1:0]  cell_word;
  logic [ttcw_pkg::INDEX_W-1:0] cursor_index;

  modport source (output valid, output cell_write, output cell_index, output cell_word,
                  output cursor_index, input ready);
  modport sink (input valid, input cell_write, input cell_index, input cell_word,
                input cursor_index, output ready);
endinterface

interface ttcw_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ttcw_pkg::COLOR_W-1:0] text_color;

  modport source (output valid, output text_color, input ready);
  modport sink (input valid, input text_color, output ready);
endinterface

`default_nettype wire

>>> hdl/text_terminal_char_writer.sv
// An accepted beat waits in the input stage; its result is registered in the result register when it steps.
// Throughput: one beat per cycle while the output is not stalled, with one cursor update per step.
// The result register lets a new beat enter an empty input stage while a finished result waits.
// Reset (rst_n low at a clock edge) puts the cursor at row 0, column 0,
// empties both stages and sets the colour attribute to 0x8A.
`default_nettype none
`include "text_terminal_char_writer_defines.svh"

module text_terminal_char_writer #(
  parameter int COLUMNS = ttcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = ttcw_pkg::ROWS_DEF
) (
  input wire logic    clk,
  input wire logic    rst_n,
  ttcw_in_if.sink     in_ch,
  ttcw_out_if.source  out_ch,
  ttcw_cfg_if.sink    cfg_ch
);

  logic                         s1_v_r;
  logic [ttcw_pkg::CHAR_W-1:0]  char_r;
  logic [ttcw_pkg::COLOR_W-1:0] color_r;
  logic                         out_v_r;
  ttcw_pkg::ttcw_result_t       res_r;
  ttcw_pkg::ttcw_result_t       result;
  logic                         adv;
  logic                         step;

  assign adv          = !out_v_r || out_ch.ready;
  assign step         = s1_v_r && adv;
  assign in_ch.ready  = !s1_v_r || adv;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= ttcw_pkg::COLOR_RESET;
    end else if (cfg_ch.valid) begin
      color_r <= cfg_ch.text_color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      char_r <= in_ch.char_code;
    end
  end

  ttcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .char_code  (char_r),
    .text_color (color_r),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= result;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.cell_write   = res_r.cell_write;
  assign out_ch.cell_index   = res_r.cell_index;
  assign out_ch.cell_word    = res_r.cell_word;
  assign out_ch.cursor_index = res_r.cursor_index;

  `TTCW_ASSERT_IMP(a_no_write_zero, out_v_r && !res_r.cell_write, (res_r.cell_index == '0) && (res_r.cell_word == '0), "Result without a cell write carries a non-zero index or word.")
  `TTCW_ASSERT_NXT(a_stall_keeps, s1_v_r && !adv, s1_v_r, "Stalled beat was lost from the input stage.")
  `TTCW_ASSERT_NXT(a_step_delivers, step, out_v_r, "Processed beat did not reach the result register.")

endmodule

`default_nettype wire

>>> hdl/ttcw_cursor.sv
`default_nettype none

module ttcw_cursor #(
  parameter int COLUMNS = ttcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = ttcw_pkg::ROWS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step,
  input  wire logic [ttcw_pkg::CHAR_W-1:0]  char_code,
  input  wire logic [ttcw_pkg::COLOR_W-1:0] text_color,
  output ttcw_pkg::ttcw_result_t            result
);

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IW = ttcw_pkg::INDEX_W;

  localparam logic [CW:0]   COLS_EXT = (CW + 1)'(COLUMNS);
  localparam logic [CW:0]   TAB_EXT  = (CW + 1)'(ttcw_pkg::TAB_STEP);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [IW-1:0] COLS_IDX = IW'(COLUMNS);

  logic [RW-1:0] row_r, row_nxt, row_inc;
  logic [CW-1:0] col_r, col_nxt;
  logic [CW:0]   sum_tab, sum_one;
  logic [IW-1:0] here_idx, next_idx;
  logic          is_write;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (step) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  always_comb begin
    row_inc  = (row_r == LAST_ROW) ? '0 : row_r + RW'(1);
    sum_tab  = {1'b0, col_r} + TAB_EXT;
    sum_one  = {1'b0, col_r} + (CW + 1)'(1);
    is_write = 1'b0;
    row_nxt  = row_r;
    col_nxt  = col_r;
    if (char_code == ttcw_pkg::CH_NEWLINE) begin
      col_nxt = '0;
      row_nxt = row_inc;
    end else if (char_code == ttcw_pkg::CH_TAB) begin
      if (sum_tab >= COLS_EXT) begin
        col_nxt = CW'(sum_tab - COLS_EXT);
        row_nxt = row_inc;
      end else begin
        col_nxt = sum_tab[CW-1:0];
      end
    end else begin
      is_write = 1'b1;
      if (sum_one >= COLS_EXT) begin
        col_nxt = '0;
        row_nxt = row_inc;
      end else begin
        col_nxt = sum_one[CW-1:0];
      end
    end
  end

  assign here_idx = IW'(row_r) * COLS_IDX + IW'(col_r);
  assign next_idx = IW'(row_nxt) * COLS_IDX + IW'(col_nxt);

  always_comb begin
    result.cell_write   = is_write;
    result.cell_index   = is_write ? here_idx : '0;
    result.cell_word    = is_write ? {text_color, char_code} : '0;
    result.cursor_index = next_idx;
  end

endmodule

`default_nettype wire

>>> tb/sv/tb_text_terminal_char_writer.sv
`timescale 1ns / 1ps

class cell_write_scoreboard;
  localparam int COLUMNS = ttcw_pkg::COLUMNS_DEF;
  localparam int ROWS    = ttcw_pkg::ROWS_DEF;

  logic [ttcw_pkg::COLOR_W-1:0] text_color;
  int unsigned                  cur_row;
  int unsigned                  cur_col;
  ttcw_pkg::ttcw_result_t       pending_cells[$];
  int unsigned                  mismatches;

  function new();
    text_color = ttcw_pkg::COLOR_RESET;
    cur_row    = 0;
    cur_col    = 0;
    mismatches = 0;
  endfunction

  function void set_color(logic [ttcw_pkg::COLOR_W-1:0] c);
    text_color = c;
  endfunction

  function logic [ttcw_pkg::INDEX_W-1:0] linear_index(int unsigned r, int unsigned c);
    int unsigned v;
    v = r * COLUMNS + c;
    return v[ttcw_pkg::INDEX_W-1:0];
  endfunction

  function void step_row();
    cur_row = (cur_row + 1 >= ROWS) ? 0 : cur_row + 1;
  endfunction

  function void note_char(logic [ttcw_pkg::CHAR_W-1:0] ch);
    ttcw_pkg::ttcw_result_t exp_cell;
    int unsigned            left;
    exp_cell = '0;
    if (ch == ttcw_pkg::CH_NEWLINE) begin
      cur_col = 0;
      step_row();
    end else if (ch == ttcw_pkg::CH_TAB) begin
      left = COLUMNS - cur_col;
      if (left > ttcw_pkg::TAB_STEP) begin
        cur_col = cur_col + ttcw_pkg::TAB_STEP;
      end else begin
        cur_col = ttcw_pkg::TAB_STEP - left;
        step_row();
      end
    end else begin
      exp_cell.cell_write = 1'b1;
      exp_cell.cell_index = linear_index(cur_row, cur_col);
      exp_cell.cell_word  = {text_color, ch};
      cur_col = cur_col + 1;
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        step_row();
      end
    end
    exp_cell.cursor_index = linear_index(cur_row, cur_col);
    pending_cells.push_back(exp_cell);
  endfunction

  function void check_cell(ttcw_pkg::ttcw_result_t got);
    ttcw_pkg::ttcw_result_t exp_cell;
    bit                     bad;
    if (pending_cells.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Unexpected result beat: write=%0d index=%0d word=%h cursor=%0d",
                 got.cell_write, got.cell_index, got.cell_word, got.cursor_index);
      return;
    end
    exp_cell = pending_cells.pop_front();
    bad = 1'b0;
    if (got.cell_write !== exp_cell.cell_write) bad = 1'b1;
    if (got.cell_index !== exp_cell.cell_index) bad = 1'b1;
    if (got.cell_word !== exp_cell.cell_word) bad = 1'b1;
    if (got.cursor_index !== exp_cell.cursor_index) bad = 1'b1;
    if (bad) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch: expected write=%0d index=%0d word=%h cursor=%0d, %s%0d %s%0d %s%h %s%0d",
                 exp_cell.cell_write, exp_cell.cell_index, exp_cell.cell_word,
                 exp_cell.cursor_index, "got write=", got.cell_write, "index=",
                 got.cell_index, "word=", got.cell_word, "cursor=", got.cursor_index);
    end
  endfunction
endclass

module tb_text_terminal_char_writer;

  logic clk = 1'b0;
  logic rst_n;
  bit   quiet = 1'b0;

  cell_write_scoreboard sb = new();

  ttcw_in_if  in_if();
  ttcw_out_if out_if();
  ttcw_cfg_if cfg_if();

  text_terminal_char_writer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    ttcw_pkg::ttcw_result_t got;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) sb.set_color(cfg_if.text_color);
      if (in_if.valid && in_if.ready) sb.note_char(in_if.char_code);
      if (out_if.valid && out_if.ready) begin
        got.cell_write   = out_if.cell_write;
        got.cell_index   = out_if.cell_index;
        got.cell_word    = out_if.cell_word;
        got.cursor_index = out_if.cursor_index;
        sb.check_cell(got);
      end
    end
  end

  initial begin
    int hold;
    out_if.ready = 1'b0;
    @(posedge clk);
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  task automatic send_char(input logic [ttcw_pkg::CHAR_W-1:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.char_code <= c;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic write_color(input logic [ttcw_pkg::COLOR_W-1:0] c);
    cfg_if.valid      <= 1'b1;
    cfg_if.text_color <= c;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_cells.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [ttcw_pkg::CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return ttcw_pkg::CH_NEWLINE;
    if (r < 27) return ttcw_pkg::CH_TAB;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic run_random(input int count);
    int sent;
    int n;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0: begin
          n = $urandom_range(60, 90);
          repeat (n) send_char(8'($urandom_range(0, 255)));
          sent += n;
        end
        1: begin
          n = $urandom_range(1, 30);
          repeat (n) send_char(ttcw_pkg::CH_NEWLINE);
          sent += n;
        end
        2: begin
          n = $urandom_range(1, 25);
          repeat (n) send_char(ttcw_pkg::CH_TAB);
          sent += n;
        end
        default: begin
          send_char(pick_char());
          sent++;
        end
      endcase
    end
  endtask

  initial begin
    logic [ttcw_pkg::COLOR_W-1:0] colors[6];
    in_if.valid       = 1'b0;
    in_if.char_code   = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.text_color = '0;
    rst_n             = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h41);
    send_char(ttcw_pkg::CH_NEWLINE);
    repeat (19) send_char(ttcw_pkg::CH_TAB);
    send_char(ttcw_pkg::CH_TAB);
    send_char(8'h08);
    drain();

    colors = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h00, 8'h00};
    colors[4] = 8'($urandom_range(0, 255));
    colors[5] = 8'($urandom_range(0, 255));
    foreach (colors[i]) begin
      write_color(colors[i]);
      quiet = (i == 2);
      run_random(125);
      drain();
    end
    quiet = 1'b0;

    if (sb.mismatches == 0 && sb.pending_cells.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end
endmodule
